// ===== rtl/onc_pkg.sv =====
`default_nettype none

package onc_pkg;

    // fixed point format and port widths
    localparam int FRAC_BITS = 15;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    // magnitude of a 16-bit signed value, and a sum of three of them
    localparam int MAG_W = IN_W;
    localparam int S_W   = MAG_W + 1;

    // squared length and its root
    localparam int LEN_W     = 2 * MAG_W;
    localparam int ROOT_W    = LEN_W / 2;
    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
    localparam int SQ_REM_W  = ROOT_W + 2;

    // divider: numerator below twice the divisor, so FRAC_BITS + 1 quotient bits
    localparam int NUM_LANES  = 3;
    localparam int DIV_W      = S_W;
    localparam int QB         = FRAC_BITS + 1;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = QB / DIV_STEPS;
    localparam int DIV_REM_W  = DIV_W + 1;
    localparam int QR_W       = QB + 1;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    localparam int FRONT_STAGES = 4;
    localparam int BACK_STAGES  = 2;
    localparam int LATENCY      = FRONT_STAGES + SQ_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [S_W-1:0]  ONE_S = S_W'(2 ** FRAC_BITS);
    localparam logic [QR_W-1:0] ONE_Q = QR_W'(2 ** FRAC_BITS);

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef struct packed {
        logic func;
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic fold;
    } t_ctl;

    typedef struct packed {
        t_ctl             ctl;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] mag_z;
        logic [S_W-1:0]   sum;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/onc_front.sv =====
`default_nettype none

module onc_front import onc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_func,
    input  logic signed [IN_W-1:0] i_x,
    input  logic signed [IN_W-1:0] i_y,
    input  logic signed [IN_W-1:0] i_z,
    output logic                   o_valid,
    output t_side                  o_side,
    output logic [LEN_W-1:0]       o_len2
);

    // stage 1: magnitudes and signs
    logic             r_v1, r_func1, r_sx, r_sy, r_sz;
    logic [MAG_W-1:0] r_ax, r_ay, r_az;
    logic [MAG_W-1:0] n_ax, n_ay, n_az;

    // stage 2: l1 norm, rebuilt z and unfold
    logic             r_v2;
    t_side            r_side2;
    t_side            n_side2;
    logic [S_W-1:0]   n_t, n_sum;
    logic             n_vzneg;
    logic [MAG_W-1:0] n_vzmag, n_ux, n_uy;

    // stage 3: squares
    logic             r_v3;
    t_side            r_side3;
    logic [LEN_W-1:0] r_sq_x, r_sq_y, r_sq_z;

    // stage 4: squared length
    logic             r_v4;
    t_side            r_side4;
    logic [LEN_W-1:0] r_len2;

    always_comb begin
        n_ax = i_x[IN_W-1] ? MAG_W'(-i_x) : MAG_W'(i_x);
        n_ay = i_y[IN_W-1] ? MAG_W'(-i_y) : MAG_W'(i_y);
        n_az = i_z[IN_W-1] ? MAG_W'(-i_z) : MAG_W'(i_z);
    end

    always_comb begin
        n_t     = {1'b0, r_ax} + {1'b0, r_ay};
        n_sum   = n_t + {1'b0, r_az};
        n_vzneg = n_t > ONE_S;
        n_vzmag = n_vzneg ? MAG_W'(n_t - ONE_S) : MAG_W'(ONE_S - n_t);
        n_ux    = MAG_W'(ONE_S - {1'b0, r_ay});
        n_uy    = MAG_W'(ONE_S - {1'b0, r_ax});

        n_side2           = '0;
        n_side2.ctl.func  = r_func1;
        n_side2.ctl.neg_x = r_sx;
        n_side2.ctl.neg_y = r_sy;
        n_side2.sum       = n_sum;
        unique case (r_func1)
            FUNC_ENCODE: begin
                // fold when z <= 0
                n_side2.ctl.fold = r_sz | (r_az == '0);
                n_side2.mag_x    = r_ax;
                n_side2.mag_y    = r_ay;
                n_side2.mag_z    = '0;
            end
            FUNC_DECODE: begin
                // unfold from the original code when z < 0
                n_side2.ctl.neg_z = n_vzneg;
                n_side2.mag_x     = n_vzneg ? n_ux : r_ax;
                n_side2.mag_y     = n_vzneg ? n_uy : r_ay;
                n_side2.mag_z     = n_vzmag;
            end
            default: begin
                n_side2.mag_x = r_ax;
                n_side2.mag_y = r_ay;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func1 <= i_func;
        r_sx    <= i_x[IN_W-1];
        r_sy    <= i_y[IN_W-1];
        r_sz    <= i_z[IN_W-1];
        r_ax    <= n_ax;
        r_ay    <= n_ay;
        r_az    <= n_az;

        r_side2 <= n_side2;

        r_side3 <= r_side2;
        r_sq_x  <= LEN_W'(r_side2.mag_x) * LEN_W'(r_side2.mag_x);
        r_sq_y  <= LEN_W'(r_side2.mag_y) * LEN_W'(r_side2.mag_y);
        r_sq_z  <= LEN_W'(r_side2.mag_z) * LEN_W'(r_side2.mag_z);

        r_side4 <= r_side3;
        r_len2  <= r_sq_x + r_sq_y + r_sq_z;
    end

    assign o_valid = r_v4;
    assign o_side  = r_side4;
    assign o_len2  = r_len2;

endmodule

`default_nettype wire

// ===== rtl/onc_sqrt.sv =====
`default_nettype none

module onc_sqrt import onc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [LEN_W-1:0]  i_rad,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic                r_valid [SQ_STAGES];
    logic [SQ_REM_W-1:0] r_rem   [SQ_STAGES];
    logic [ROOT_W-1:0]   r_root  [SQ_STAGES];
    logic [LEN_W-1:0]    r_rad   [SQ_STAGES];
    t_side               r_side  [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
        logic                s_valid;
        logic [SQ_REM_W-1:0] s_rem;
        logic [ROOT_W-1:0]   s_root;
        logic [LEN_W-1:0]    s_rad;
        t_side               s_side;
        logic [SQ_REM_W-1:0] c_rem;
        logic [ROOT_W-1:0]   c_root;
        logic [LEN_W-1:0]    c_rad;

        if (g == 0) begin : g_first
            assign s_valid = i_valid;
            assign s_rem   = '0;
            assign s_root  = '0;
            assign s_rad   = i_rad;
            assign s_side  = i_side;
        end else begin : g_next
            assign s_valid = r_valid[g-1];
            assign s_rem   = r_rem[g-1];
            assign s_root  = r_root[g-1];
            assign s_rad   = r_rad[g-1];
            assign s_side  = r_side[g-1];
        end

        // two digit steps: bring down two radicand bits, try 4*root+1
        always_comb begin
            logic [SQ_REM_W+1:0] rem_sh;
            logic [SQ_REM_W-1:0] trial;
            c_rem  = s_rem;
            c_root = s_root;
            c_rad  = s_rad;
            for (int k = 0; k < SQ_STEPS; k++) begin
                rem_sh = {c_rem, c_rad[LEN_W-1 -: 2]};
                trial  = {c_root, 2'b01};
                if (rem_sh >= {2'b00, trial}) begin
                    c_rem  = SQ_REM_W'(rem_sh - {2'b00, trial});
                    c_root = {c_root[ROOT_W-2:0], 1'b1};
                end else begin
                    c_rem  = SQ_REM_W'(rem_sh);
                    c_root = {c_root[ROOT_W-2:0], 1'b0};
                end
                c_rad = {c_rad[LEN_W-3:0], 2'b00};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= c_rem;
            r_root[g] <= c_root;
            r_rad[g]  <= c_rad;
            r_side[g] <= s_side;
        end
    end

    assign o_valid = r_valid[SQ_STAGES-1];
    assign o_root  = r_root[SQ_STAGES-1];
    assign o_side  = r_side[SQ_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/onc_div.sv =====
`default_nettype none

module onc_div import onc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [DIV_W-1:0]     i_den,
    input  logic [MAG_W-1:0]     i_num [NUM_LANES],
    input  t_ctl                 i_ctl,
    output logic                 o_valid,
    output logic [DIV_W-1:0]     o_den,
    output logic [QB-1:0]        o_quo [NUM_LANES],
    output logic [DIV_REM_W-1:0] o_rem [NUM_LANES],
    output t_ctl                 o_ctl
);

    logic                 r_valid [DIV_STAGES];
    logic [DIV_W-1:0]     r_den   [DIV_STAGES];
    logic [DIV_REM_W-1:0] r_rem   [DIV_STAGES][NUM_LANES];
    logic [QB-1:0]        r_quo   [DIV_STAGES][NUM_LANES];
    t_ctl                 r_ctl   [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic                 s_valid;
        logic [DIV_W-1:0]     s_den;
        logic [DIV_REM_W-1:0] s_rem [NUM_LANES];
        logic [QB-1:0]        s_quo [NUM_LANES];
        t_ctl                 s_ctl;
        logic [DIV_REM_W-1:0] c_rem [NUM_LANES];
        logic [QB-1:0]        c_quo [NUM_LANES];

        if (g == 0) begin : g_first
            always_comb begin
                s_valid = i_valid;
                s_den   = i_den;
                s_ctl   = i_ctl;
                for (int l = 0; l < NUM_LANES; l++) begin
                    s_rem[l] = DIV_REM_W'(i_num[l]);
                    s_quo[l] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                s_valid = r_valid[g-1];
                s_den   = r_den[g-1];
                s_ctl   = r_ctl[g-1];
                s_rem   = r_rem[g-1];
                s_quo   = r_quo[g-1];
            end
        end

        // restoring steps; the remainder is kept doubled for the next bit
        always_comb begin
            logic [DIV_REM_W-1:0] rem;
            logic [QB-1:0]        quo;
            for (int l = 0; l < NUM_LANES; l++) begin
                rem = s_rem[l];
                quo = s_quo[l];
                for (int k = 0; k < DIV_STEPS; k++) begin
                    if (rem >= {1'b0, s_den}) begin
                        rem = rem - {1'b0, s_den};
                        quo = {quo[QB-2:0], 1'b1};
                    end else begin
                        quo = {quo[QB-2:0], 1'b0};
                    end
                    rem = {rem[DIV_REM_W-2:0], 1'b0};
                end
                c_rem[l] = rem;
                c_quo[l] = quo;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= s_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[g] <= s_den;
            r_ctl[g] <= s_ctl;
            r_rem[g] <= c_rem;
            r_quo[g] <= c_quo;
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_den   = r_den[DIV_STAGES-1];
    assign o_ctl   = r_ctl[DIV_STAGES-1];
    assign o_quo   = r_quo[DIV_STAGES-1];
    assign o_rem   = r_rem[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/onc_back.sv =====
`default_nettype none

module onc_back import onc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic [DIV_W-1:0]        i_den,
    input  logic [QB-1:0]           i_quo [NUM_LANES],
    input  logic [DIV_REM_W-1:0]    i_rem [NUM_LANES],
    input  t_ctl                    i_ctl,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_x,
    output logic signed [OUT_W-1:0] o_y,
    output logic signed [OUT_W-1:0] o_z,
    output logic                    o_zero
);

    localparam logic [QR_W-1:0] MAX_POS = QR_W'(2 ** (OUT_W - 1) - 1);
    localparam logic [QR_W-1:0] MAX_NEG = QR_W'(2 ** (OUT_W - 1));

    logic            r_b_valid;
    logic [QR_W-1:0] r_b_mag [NUM_LANES];
    logic            r_b_neg [NUM_LANES];
    logic            r_b_zv;

    logic [QR_W-1:0] n_qr  [NUM_LANES];
    logic [QR_W-1:0] n_mag [NUM_LANES];
    logic            n_neg [NUM_LANES];
    logic            n_zero;

    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_x, r_o_y, r_o_z;
    logic                    r_o_zero;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic neg,
                                                         input logic [QR_W-1:0] mag);
        logic signed [OUT_W-1:0] v;
        if (neg) begin
            v = (mag >= MAX_NEG) ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(~mag + 1'b1);
        end else begin
            v = (mag >= MAX_POS) ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(mag);
        end
        return v;
    endfunction

    // round to nearest, fold the code for the lower hemisphere, and clear every lane on a zero divisor
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_qr[l] = QR_W'(i_quo[l]) + QR_W'(i_rem[l] >= {1'b0, i_den});
        end
        n_zero = (i_den == '0);

        n_neg[LANE_X] = i_ctl.neg_x;
        n_neg[LANE_Y] = i_ctl.neg_y;
        n_neg[LANE_Z] = i_ctl.neg_z;
        if (i_ctl.fold) begin
            n_mag[LANE_X] = ONE_Q - n_qr[LANE_Y];
            n_mag[LANE_Y] = ONE_Q - n_qr[LANE_X];
        end else begin
            n_mag[LANE_X] = n_qr[LANE_X];
            n_mag[LANE_Y] = n_qr[LANE_Y];
        end
        n_mag[LANE_Z] = (i_ctl.func == FUNC_DECODE) ? n_qr[LANE_Z] : '0;

        if (n_zero) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                n_mag[l] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_b_valid <= i_valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mag  <= n_mag;
        r_b_neg  <= n_neg;
        r_b_zv   <= n_zero && (i_ctl.func == FUNC_ENCODE);

        r_o_x    <= sat_out(r_b_neg[LANE_X], r_b_mag[LANE_X]);
        r_o_y    <= sat_out(r_b_neg[LANE_Y], r_b_mag[LANE_Y]);
        r_o_z    <= sat_out(r_b_neg[LANE_Z], r_b_mag[LANE_Z]);
        r_o_zero <= r_b_zv;
    end

    assign o_valid = r_o_valid;
    assign o_x     = r_o_x;
    assign o_y     = r_o_y;
    assign o_z     = r_o_z;
    assign o_zero  = r_o_zero;

endmodule

`default_nettype wire

// ===== rtl/octahedral_normal_codec.sv =====
`default_nettype none

// Octahedral codec for Q1.15 unit vectors: i_func low encodes (x, y, z) into a
// two-component code, i_func high decodes a code back into a unit vector. The
// block is fully pipelined and takes one item in every clock: busy never rises,
// so start alone transfers an item. Each result appears on the output ports for
// exactly one cycle with o_valid high; the receiver cannot hold results off, so
// it must take every strobe. The pipeline is made up of the square root (16 digit
// steps, two per stage, 8 stages) and the three-lane divider (16 quotient bits,
// two per stage, 8 stages), plus four front stages (magnitudes, fold, squares,
// length) and two output stages (rounding and fold, saturation). Encode items
// pass through the root stages unchanged and divide by the l1 norm.
module octahedral_normal_codec import onc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_func,
    input  logic signed [IN_W-1:0]  i_in_x,
    input  logic signed [IN_W-1:0]  i_in_y,
    input  logic signed [IN_W-1:0]  i_in_z,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_out_x,
    output logic signed [OUT_W-1:0] o_out_y,
    output logic signed [OUT_W-1:0] o_out_z,
    output logic                    o_zero_vector
);

    logic                 accept;

    logic                 fr_valid;
    t_side                fr_side;
    logic [LEN_W-1:0]     fr_len2;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    t_side                sq_side;

    logic [DIV_W-1:0]     dv_den_in;
    logic [MAG_W-1:0]     dv_num [NUM_LANES];

    logic                 dv_valid;
    logic [DIV_W-1:0]     dv_den;
    logic [QB-1:0]        dv_quo [NUM_LANES];
    logic [DIV_REM_W-1:0] dv_rem [NUM_LANES];
    t_ctl                 dv_ctl;

    // no stall anywhere in the pipeline
    assign busy   = 1'b0;
    assign accept = start && !busy;

    onc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_func  (i_func),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .o_valid (fr_valid),
        .o_side  (fr_side),
        .o_len2  (fr_len2)
    );

    onc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .i_rad   (fr_len2),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // decode divides by the vector length, encode by the l1 norm
    always_comb begin
        dv_den_in = (sq_side.ctl.func == FUNC_DECODE) ? DIV_W'(sq_root) : sq_side.sum;
        dv_num[LANE_X] = sq_side.mag_x;
        dv_num[LANE_Y] = sq_side.mag_y;
        dv_num[LANE_Z] = sq_side.mag_z;
    end

    onc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_den   (dv_den_in),
        .i_num   (dv_num),
        .i_ctl   (sq_side.ctl),
        .o_valid (dv_valid),
        .o_den   (dv_den),
        .o_quo   (dv_quo),
        .o_rem   (dv_rem),
        .o_ctl   (dv_ctl)
    );

    onc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .i_den   (dv_den),
        .i_quo   (dv_quo),
        .i_rem   (dv_rem),
        .i_ctl   (dv_ctl),
        .o_valid (o_valid),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z),
        .o_zero  (o_zero_vector)
    );

endmodule

`default_nettype wire

// ===== rtl/onc_checker.sv =====
`default_nettype none

module onc_checker import onc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic                    i_func,
    input  logic signed [IN_W-1:0]  i_in_x,
    input  logic signed [IN_W-1:0]  i_in_y,
    input  logic signed [IN_W-1:0]  i_in_z,
    input  logic                    o_valid,
    input  logic signed [OUT_W-1:0] o_out_x,
    input  logic signed [OUT_W-1:0] o_out_y,
    input  logic signed [OUT_W-1:0] o_out_z,
    input  logic                    o_zero_vector
);

    // every transfer comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted item produced no result at the expected latency");

    // no result without a transfer at the matching start edge
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, LATENCY))
        else $error("result strobe without a matching transfer");

    // zero flag only for an encode of the all-zero vector
    a_zero_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |-> $past(i_func == FUNC_ENCODE && i_in_x == '0
            && i_in_y == '0 && i_in_z == '0, LATENCY))
        else $error("zero vector flag without an all-zero encode input");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_vector) |-> (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("zero vector result with nonzero components");

    a_enc_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_func == FUNC_ENCODE, LATENCY)) |-> (o_out_z == '0))
        else $error("encode result with nonzero z");

endmodule

bind octahedral_normal_codec onc_checker u_onc_checker (.*);

`default_nettype wire
